@@ rtl/plc_pkg.sv @@
// Shared types and constants for the point list convolution unit.
// Depends on nothing; imported by the top level and its checker.
package plc_pkg;

  // Operation codes carried on the op port.
  localparam logic [1:0] OP_WR_PIXEL = 2'd0;
  localparam logic [1:0] OP_WR_COEF  = 2'd1;
  localparam logic [1:0] OP_CONV     = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_ROWS   = 2'd0;
  localparam logic [1:0] REG_COLS   = 2'd1;
  localparam logic [1:0] REG_KWIDTH = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [7:0] ROWS_RESET   = 8'd128;
  localparam logic [7:0] COLS_RESET   = 8'd128;
  localparam logic [2:0] KWIDTH_RESET = 3'd3;

  // Data widths: 8-bit pixels, Q4.12 coefficients, one tap product.
  localparam int PIXW      = 8;
  localparam int COEFW     = 16;
  localparam int PRODW     = PIXW + 1 + COEFW;
  localparam int FRAC_BITS = 12;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_CENTER,
    S_WAITC,
    S_TAPS,
    S_DRAIN,
    S_FINISH
  } state_t;

endpackage

@@ rtl/point_list_convolution_unit.sv @@
// Top level of the point list convolution unit: image and kernel memories,
// tap sequencer and multiply-accumulate path. Depends on plc_pkg.
//
// Pixel and coefficient write items never raise busy.
// A convolve item at a point whose k x k window lies inside the image walks
// the window one tap per cycle through the single read port of the pixel
// memory. The memory reads, the product and the sum are registered in turn,
// and the saturated sum is registered onto the result outputs from S_FINISH.
// The next item can be accepted at the edge that ends the result strobe. A
// point on the border makes one memory read of the center pixel, through
// S_CENTER and S_WAITC, and a point outside the image gives its result in
// the cycle right after acceptance. Every result is shown for exactly one
// cycle on result_valid and is never held back.
module point_list_convolution_unit
  import plc_pkg::*;
#(
  parameter int MAX_ROWS   = 128,
  parameter int MAX_COLS   = 128,
  parameter int MAX_KERNEL = 5
) (
  input  logic              clk,
  input  logic              rst,
  // Item channel.
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        op,
  input  logic [6:0]        row,
  input  logic [6:0]        col,
  input  logic signed [15:0] value,
  // Configuration write port.
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [7:0]        cfg_data,
  // Result channel.
  output logic              result_valid,
  output logic [6:0]        out_row,
  output logic [6:0]        out_col,
  output logic [7:0]        out_pixel,
  output logic              applied,
  output logic              clipped
);

  localparam int PIX_DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int AW         = $clog2(PIX_DEPTH);
  localparam int COEF_DEPTH = MAX_KERNEL * MAX_KERNEL;
  localparam int CAW        = (COEF_DEPTH > 1) ? $clog2(COEF_DEPTH) : 1;
  localparam int ACCW       = PRODW + $clog2(COEF_DEPTH + 1);

  // Configuration registers.
  logic [7:0] image_rows;
  logic [7:0] image_cols;
  logic [2:0] kernel_width;

  // Sequencer and item registers.
  state_t     state, state_next;
  logic [6:0] row_q, col_q;
  logic [2:0] k_q;
  logic [1:0] h_q;
  logic [2:0] kr, kc;

  // Memories and their read data registers.
  logic [PIXW-1:0]  pix_mem  [PIX_DEPTH];
  logic [COEFW-1:0] coef_mem [COEF_DEPTH];
  logic [PIXW-1:0]  pix_q;
  logic [COEFW-1:0] coef_q;

  // Multiply-accumulate pipeline.
  logic                    rd_v, prod_v;
  logic signed [PRODW-1:0] prod;
  logic signed [ACCW-1:0]  acc;

  // Decoded item and configuration.
  logic           accept, conv_item;
  logic [8:0]     rows_eff, cols_eff;
  logic [2:0]     k_eff;
  logic [1:0]     h_eff;
  logic           in_img, fits;
  logic           wr_pix_ok, wr_coef_ok;
  logic [AW-1:0]  pix_waddr, pix_raddr;
  logic [CAW-1:0] coef_waddr, coef_raddr;
  logic [7:0]     pr, pc;
  logic           last_tap;

  // Saturation of the finished sum.
  logic [ACCW-13:0] acc_hi;
  logic             acc_neg, neg_clip, pos_clip;
  logic [7:0]       sat_pixel;

  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign conv_item = accept && (op == OP_CONV);

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_rows   <= ROWS_RESET;
      image_cols   <= COLS_RESET;
      kernel_width <= KWIDTH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROWS:   image_rows   <= cfg_data;
        REG_COLS:   image_cols   <= cfg_data;
        REG_KWIDTH: kernel_width <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // Effective image size and kernel side after saturation.
  always_comb begin
    rows_eff = (32'(image_rows) > MAX_ROWS) ? 9'(MAX_ROWS) : {1'b0, image_rows};
    cols_eff = (32'(image_cols) > MAX_COLS) ? 9'(MAX_COLS) : {1'b0, image_cols};
    if (kernel_width == 3'd0) begin
      k_eff = 3'd1;
    end else if (32'(kernel_width) > MAX_KERNEL) begin
      k_eff = 3'(MAX_KERNEL);
    end else begin
      k_eff = kernel_width;
    end
    h_eff = k_eff[2:1];
  end

  // Point classification: inside the image, and whole window inside.
  always_comb begin
    in_img = (9'(row) < rows_eff) && (9'(col) < cols_eff);
    fits   = in_img && (9'(row) >= 9'(h_eff)) && (9'(row) + 9'(h_eff) < rows_eff) &&
             (9'(col) >= 9'(h_eff)) && (9'(col) + 9'(h_eff) < cols_eff);
  end

  // Write addresses and range checks.
  always_comb begin
    wr_pix_ok  = (32'(row) < MAX_ROWS) && (32'(col) < MAX_COLS);
    wr_coef_ok = (32'(row) < MAX_KERNEL) && (32'(col) < MAX_KERNEL);
    pix_waddr  = AW'(AW'(row) * AW'(MAX_COLS)) + AW'(col);
    coef_waddr = CAW'(CAW'(row) * CAW'(MAX_KERNEL)) + CAW'(col);
  end

  // Read addresses from the tap counters; the center read uses kr = kc = h.
  always_comb begin
    pr         = 8'(row_q) + 8'(kr) - 8'(h_q);
    pc         = 8'(col_q) + 8'(kc) - 8'(h_q);
    pix_raddr  = AW'(AW'(pr) * AW'(MAX_COLS)) + AW'(pc);
    coef_raddr = CAW'(CAW'(kr) * CAW'(MAX_KERNEL)) + CAW'(kc);
    last_tap   = (kr == k_q - 3'd1) && (kc == k_q - 3'd1);
  end

  // Pixel memory. Writes only happen while idle and read data is only used
  // while busy, so a used read never meets a write to the same entry.
  always_ff @(posedge clk) begin
    if (accept && (op == OP_WR_PIXEL) && wr_pix_ok) begin
      pix_mem[pix_waddr] <= value[PIXW-1:0];
    end
    pix_q <= pix_mem[pix_raddr];
  end

  // Coefficient memory.
  always_ff @(posedge clk) begin
    if (accept && (op == OP_WR_COEF) && wr_coef_ok) begin
      coef_mem[coef_waddr] <= value;
    end
    coef_q <= coef_mem[coef_raddr];
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (conv_item && in_img) begin
          state_next = fits ? S_TAPS : S_CENTER;
        end
      end
      S_CENTER: state_next = S_WAITC;
      S_WAITC:  state_next = S_IDLE;
      S_TAPS: begin
        if (last_tap) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!rd_v) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Item registers and tap counters.
  always_ff @(posedge clk) begin
    if (conv_item) begin
      row_q <= row;
      col_q <= col;
      k_q   <= k_eff;
      h_q   <= h_eff;
      kr    <= fits ? 3'd0 : {1'b0, h_eff};
      kc    <= fits ? 3'd0 : {1'b0, h_eff};
    end else if (state == S_TAPS) begin
      if (kc == k_q - 3'd1) begin
        kc <= 3'd0;
        kr <= kr + 3'd1;
      end else begin
        kc <= kc + 3'd1;
      end
    end
  end

  // Pipeline valid flags: read issued, product ready.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v   <= 1'b0;
      prod_v <= 1'b0;
    end else begin
      rd_v   <= (state == S_TAPS);
      prod_v <= rd_v;
    end
  end

  // Product register, then the accumulator.
  always_ff @(posedge clk) begin
    prod <= $signed({1'b0, pix_q}) * $signed(coef_q);
    if (conv_item) begin
      acc <= '0;
    end else if (prod_v) begin
      acc <= acc + ACCW'(prod);
    end
  end

  // Truncate toward zero and saturate to 0..255.
  always_comb begin
    acc_hi    = acc[ACCW-1:FRAC_BITS];
    acc_neg   = acc[ACCW-1];
    // Sums in -4095..-1 truncate to zero without clipping.
    neg_clip  = acc_neg && !((&acc_hi) && (acc[FRAC_BITS-1:0] != '0));
    pos_clip  = !acc_neg && (|acc[ACCW-2:FRAC_BITS+8]);
    if (acc_neg) begin
      sat_pixel = 8'd0;
    end else if (pos_clip) begin
      sat_pixel = 8'hFF;
    end else begin
      sat_pixel = acc[FRAC_BITS+7:FRAC_BITS];
    end
  end

  // Result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= (conv_item && !in_img) || (state == S_WAITC) || (state == S_FINISH);
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (conv_item && !in_img) begin
      out_row   <= row;
      out_col   <= col;
      out_pixel <= 8'd0;
      applied   <= 1'b0;
      clipped   <= 1'b0;
    end else if (state == S_WAITC) begin
      out_row   <= row_q;
      out_col   <= col_q;
      out_pixel <= pix_q;
      applied   <= 1'b0;
      clipped   <= 1'b0;
    end else if (state == S_FINISH) begin
      out_row   <= row_q;
      out_col   <= col_q;
      out_pixel <= sat_pixel;
      applied   <= 1'b1;
      clipped   <= neg_clip || pos_clip;
    end
  end

endmodule

@@ rtl/plc_checker.sv @@
// Port-level checker for the point list convolution unit, with its bind.
// Depends on plc_pkg and on the top level's port names.
module plc_checker
  import plc_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic [1:0] op,
  input logic       result_valid,
  input logic       applied,
  input logic       clipped
);

  // A write item or an unused code never produces a result.
  a_write_no_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (op != OP_CONV)) |=> !result_valid)
    else $error("result after a non-convolve item");

  // Whenever the unit finishes an item, its result shows in that cycle.
  a_done_gives_result: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $fell(busy)) |-> result_valid)
    else $error("busy fell without a result");

  // A result comes only from an accepted item or from work in progress.
  a_result_has_cause: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !$past(rst)) |-> ($past(busy) || $past(start)))
    else $error("result with no item behind it");

  // An unapplied result is never marked as saturated.
  a_clip_needs_apply: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !applied) |-> !clipped)
    else $error("clipped set on an unapplied result");

endmodule

bind point_list_convolution_unit plc_checker u_plc_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .op           (op),
  .result_valid (result_valid),
  .applied      (applied),
  .clipped      (clipped)
);
